@@ src/assert_macros.svh @@
// assertion macros for the keypad scanner rtl
// used by keypad_matrix_debounce_scanner, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/kmds_pkg.sv @@
// constants, types and helper functions for the keypad matrix scanner
// no dependencies
`default_nettype none

package kmds_pkg;

   localparam int ROWS  = 4;
   localparam int COLS  = 4;
   localparam int NKEYS = ROWS * COLS;

   localparam int TIME_W = 32;
   localparam int VEC_W  = 4;
   localparam int KEY_W  = 4;
   localparam int ACT_W  = 2;
   localparam int CFG_W  = 10;
   localparam int IDX_W  = 1;

   localparam logic [VEC_W-1:0] ROW_MASK = VEC_W'((1 << ROWS) - 1);
   localparam logic [VEC_W-1:0] COL_MASK = VEC_W'((1 << COLS) - 1);

   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DOWN = 2'd1;
   localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

   localparam logic [IDX_W-1:0] REG_DEBOUNCE = 1'd0;
   localparam logic [IDX_W-1:0] REG_TIMEOUT  = 1'd1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 10'd10;
   localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 10'd100;

   localparam int REQ_W = 40;
   localparam int RSP_W = 8;

   typedef logic [NKEYS-1:0] key_map_type;

   function automatic logic single_bit(input logic [VEC_W-1:0] v);
      single_bit = (v != '0) && ((v & (v - VEC_W'(1))) == '0);
   endfunction

   function automatic logic [1:0] lowest_bit(input logic [VEC_W-1:0] v);
      logic [1:0] idx;
      idx = 2'd0;
      for (int i = VEC_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = 2'(i);
         end
      end
      lowest_bit = idx;
   endfunction

   function automatic logic [KEY_W-1:0] lowest_key(input key_map_type m);
      logic [KEY_W-1:0] idx;
      idx = '0;
      for (int i = NKEYS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = KEY_W'(i);
         end
      end
      lowest_key = idx;
   endfunction

endpackage

`default_nettype wire

@@ src/keypad_matrix_debounce_scanner.sv @@
// keypad matrix scanner: one scan sample in, one key event out,
// one transaction per cycle while rsp_tready does not stall the result register; each req
// passes the input register, then the result register, a pass that also updates key state
// reset (synchronous, active high) clears pending wait, last vectors and the key map,
// marks all keys released and loads debounce 10 ms and timeout 100 ms
// depends on kmds_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module keypad_matrix_debounce_scanner (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [kmds_pkg::REQ_W-1:0]       req_tdata,   // now_ms, row_bits, col_bits
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [kmds_pkg::RSP_W-1:0]       rsp_tdata,   // action, key_index, zero pad
   input  wire                              csr_we,
   input  wire  [kmds_pkg::IDX_W-1:0]       csr_index,
   input  wire  [kmds_pkg::CFG_W-1:0]       csr_wdata
);

   // config registers
   logic [kmds_pkg::CFG_W-1:0]  debounce_ff, timeout_ff;

   // input stage
   logic                        in_valid_ff;
   logic [kmds_pkg::TIME_W-1:0] now_ff;
   logic [kmds_pkg::VEC_W-1:0]  rows_ff, cols_ff;

   // output stage
   logic                        out_valid_ff;
   logic [kmds_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [kmds_pkg::KEY_W-1:0]  code_ff, code_in;

   // scanner state
   logic                        pend_ff, pend_in;
   logic [kmds_pkg::TIME_W-1:0] pend_time_ff, pend_time_in;
   logic [kmds_pkg::VEC_W-1:0]  prev_rows_ff, prev_rows_in;
   logic [kmds_pkg::VEC_W-1:0]  prev_cols_ff, prev_cols_in;
   kmds_pkg::key_map_type       map_ff, map_in;
   logic                        released_ff, released_in;

   logic                        advance;
   logic [kmds_pkg::TIME_W-1:0] elapsed;
   logic                        hold;
   logic [kmds_pkg::VEC_W-1:0]  rchg, cchg, rsel, csel;
   logic [1:0]                  r_idx, c_idx;
   logic [kmds_pkg::KEY_W-1:0]  key;
   logic                        pressed;
   logic                        done;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, code_ff, act_ff};

   assign elapsed = now_ff - pend_time_ff;
   assign hold    = pend_ff && (elapsed < {22'd0, debounce_ff});
   assign rchg    = rows_ff ^ prev_rows_ff;
   assign cchg    = cols_ff ^ prev_cols_ff;

   always_comb begin
      pend_in      = pend_ff;
      pend_time_in = pend_time_ff;
      prev_rows_in = prev_rows_ff;
      prev_cols_in = prev_cols_ff;
      map_in       = map_ff;
      released_in  = released_ff;
      act_in       = kmds_pkg::ACT_NONE;
      code_in      = '0;
      done         = 1'b0;
      rsel         = rchg;
      csel         = cchg;
      if (rchg == '0) begin
         if (kmds_pkg::single_bit(rows_ff)) begin
            rsel = rows_ff;
         end
      end else if (cchg == '0) begin
         if (kmds_pkg::single_bit(cols_ff)) begin
            csel = cols_ff;
         end
      end
      r_idx   = kmds_pkg::lowest_bit(rsel);
      c_idx   = kmds_pkg::lowest_bit(csel);
      pressed = rows_ff[r_idx] && cols_ff[c_idx];
      key     = kmds_pkg::KEY_W'(r_idx * kmds_pkg::COLS + c_idx);
      if (!hold) begin
         if (rchg != '0 || cchg != '0) begin
            if (!pend_ff) begin
               pend_in      = 1'b1;
               pend_time_in = now_ff;
            end else if (rsel != '0 && csel != '0) begin
               prev_rows_in = rows_ff;
               prev_cols_in = cols_ff;
               released_in  = 1'b0;
               pend_in      = 1'b0;
               if (pressed && !map_ff[key]) begin
                  map_in[key] = 1'b1;
                  act_in      = kmds_pkg::ACT_DOWN;
                  code_in     = key;
                  done        = 1'b1;
               end else if (!pressed && map_ff[key]) begin
                  map_in[key] = 1'b0;
                  act_in      = kmds_pkg::ACT_UP;
                  code_in     = key;
                  done        = 1'b1;
               end
            end
         end else if (pend_ff && elapsed >= {22'd0, timeout_ff}) begin
            pend_in = 1'b0;
         end
         if (!done && !released_in && rows_ff == '0 && cols_ff == '0) begin
            if (map_ff != '0) begin
               code_in                                  = kmds_pkg::lowest_key(map_ff);
               map_in[kmds_pkg::lowest_key(map_ff)]     = 1'b0;
               act_in                                   = kmds_pkg::ACT_UP;
            end else begin
               released_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kmds_pkg::DEBOUNCE_RESET;
         timeout_ff  <= kmds_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kmds_pkg::REG_DEBOUNCE: debounce_ff <= csr_wdata;
            kmds_pkg::REG_TIMEOUT:  timeout_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff  <= req_tdata[31:0];
         rows_ff <= req_tdata[35:32] & kmds_pkg::ROW_MASK;
         cols_ff <= req_tdata[39:36] & kmds_pkg::COL_MASK;
      end
      if (in_valid_ff && advance) begin
         act_ff  <= act_in;
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         pend_time_ff <= '0;
         prev_rows_ff <= '0;
         prev_cols_ff <= '0;
         map_ff       <= '0;
         released_ff  <= 1'b1;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_valid_ff && advance) begin
            pend_ff      <= pend_in;
            pend_time_ff <= pend_time_in;
            prev_rows_ff <= prev_rows_in;
            prev_cols_ff <= prev_cols_in;
            map_ff       <= map_in;
            released_ff  <= released_in;
         end
      end
   end

   // all-released flag implies an empty key map
   `ASSERT_IMPLY(a_released_empty, clock, reset, released_ff, map_ff == '0)
   // a shown down event matches a set mark
   `ASSERT_IMPLY(a_down_marked, clock, reset,
      out_valid_ff && act_ff == kmds_pkg::ACT_DOWN, map_ff[code_ff])
   // a shown up event matches a cleared mark
   `ASSERT_IMPLY(a_up_cleared, clock, reset,
      out_valid_ff && act_ff == kmds_pkg::ACT_UP, !map_ff[code_ff])
   // a stalled result holds the key map and the pending flag
   `ASSERT_NEXT(a_stall_state, clock, reset,
      out_valid_ff && !rsp_tready, $stable(map_ff) && $stable(pend_ff))

endmodule

`default_nettype wire

@@ bench/keypad_matrix_debounce_scanner_tb.sv @@
`timescale 1ns / 100ps
// self-checking bench for keypad_matrix_debounce_scanner: scan samples in, key events out
// a class tracks debounce state and key map to predict each event; depends on kmds_pkg

module keypad_matrix_debounce_scanner_tb;
   import kmds_pkg::*;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
   } key_event_type;

   class key_event_tracker;
      logic [CFG_W-1:0]  settle_ms  = DEBOUNCE_RESET;
      logic [CFG_W-1:0]  abandon_ms = TIMEOUT_RESET;
      bit                waiting    = 1'b0;
      logic [TIME_W-1:0] wait_start = '0;
      logic [VEC_W-1:0]  last_rows  = '0;
      logic [VEC_W-1:0]  last_cols  = '0;
      key_map_type       held       = '0;
      bit                all_up     = 1'b1;
      key_event_type     queued[$];
      int                mismatches = 0;

      function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == REG_DEBOUNCE) begin
            settle_ms = val;
         end else begin
            abandon_ms = val;
         end
      endfunction

      function int first_set(logic [VEC_W-1:0] v);
         for (int i = 0; i < VEC_W; i++) begin
            if (v[i]) begin
               return i;
            end
         end
         return 0;
      endfunction

      function void push_event(logic [ACT_W-1:0] act, int key);
         key_event_type e;
         e.action = act;
         e.key    = (act == ACT_NONE) ? '0 : KEY_W'(key);
         queued.push_back(e);
      endfunction

      function void note_scan(logic [TIME_W-1:0] now, logic [VEC_W-1:0] rows_in,
                              logic [VEC_W-1:0] cols_in);
         logic [TIME_W-1:0] elapsed;
         logic [VEC_W-1:0]  rows;
         logic [VEC_W-1:0]  cols;
         logic [VEC_W-1:0]  rchg;
         logic [VEC_W-1:0]  cchg;
         int                r;
         int                c;
         int                k;
         bit                pressed;
         rows    = rows_in & ROW_MASK;
         cols    = cols_in & COL_MASK;
         elapsed = now - wait_start;
         if (waiting && elapsed < TIME_W'(settle_ms)) begin
            push_event(ACT_NONE, 0);
            return;
         end
         rchg = rows ^ last_rows;
         cchg = cols ^ last_cols;
         if (rchg != '0 || cchg != '0) begin
            if (!waiting) begin
               waiting    = 1'b1;
               wait_start = now;
            end else begin
               if (rchg == '0) begin
                  if ($onehot(rows)) rchg = rows;
               end else if (cchg == '0) begin
                  if ($onehot(cols)) cchg = cols;
               end
               if (rchg != '0 && cchg != '0) begin
                  r         = first_set(rchg);
                  c         = first_set(cchg);
                  pressed   = rows[r] && cols[c];
                  k         = r * COLS + c;
                  last_rows = rows;
                  last_cols = cols;
                  all_up    = 1'b0;
                  waiting   = 1'b0;
                  if (k < NKEYS) begin
                     if (pressed && !held[k]) begin
                        held[k] = 1'b1;
                        push_event(ACT_DOWN, k);
                        return;
                     end
                     if (!pressed && held[k]) begin
                        held[k] = 1'b0;
                        push_event(ACT_UP, k);
                        return;
                     end
                  end
               end
            end
         end else if (waiting && elapsed >= TIME_W'(abandon_ms)) begin
            waiting = 1'b0;
         end
         if (!all_up && rows == '0 && cols == '0) begin
            for (int i = 0; i < NKEYS; i++) begin
               if (held[i]) begin
                  held[i] = 1'b0;
                  push_event(ACT_UP, i);
                  return;
               end
            end
            all_up = 1'b1;
         end
         push_event(ACT_NONE, 0);
      endfunction

      function void check_event(logic [RSP_W-1:0] data);
         key_event_type e;
         if (queued.size() == 0) begin
            $display("%0t: unexpected event, expected none, got action %0d key %0d",
                     $time, data[1:0], data[5:2]);
            mismatches++;
            return;
         end
         e = queued.pop_front();
         if (data[1:0] !== e.action || data[5:2] !== e.key) begin
            $display("%0t: event mismatch, expected action %0d key %0d, got action %0d key %0d",
                     $time, e.action, e.key, data[1:0], data[5:2]);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata   = '0;   // now_ms, row_bits, col_bits
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;          // action, key_index, zero pad
   logic               csr_we      = 1'b0;
   logic [IDX_W-1:0]   csr_index   = REG_DEBOUNCE;
   logic [CFG_W-1:0]   csr_wdata   = '0;

   key_event_tracker   tracker     = new;
   bit                 steady      = 1'b0;
   logic [TIME_W-1:0]  stamp       = '0;
   int                 sent        = 0;

   keypad_matrix_debounce_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic send_at(input logic [TIME_W-1:0] t, input logic [VEC_W-1:0] rows,
                          input logic [VEC_W-1:0] cols);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cols, rows, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_scan(t, rows, cols);
      stamp = t;
      sent++;
   endtask

   function automatic logic [TIME_W-1:0] settle_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return tracker.settle_ms + $urandom_range(0, 3);
      if (pick < 82) return $urandom_range(0, tracker.settle_ms);
      if (pick < 94) return tracker.abandon_ms + $urandom_range(0, 2);
      return $urandom;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.queued.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] tmo);
      csr_we    <= 1'b1;
      csr_index <= REG_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      tracker.set_register(REG_DEBOUNCE, deb);
      csr_index <= REG_TIMEOUT;
      csr_wdata <= tmo;
      @(posedge clock);
      tracker.set_register(REG_TIMEOUT, tmo);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic tap_key();
      logic [VEC_W-1:0] rv;
      logic [VEC_W-1:0] cv;
      rv = VEC_W'(1) << $urandom_range(0, ROWS - 1);
      cv = VEC_W'(1) << $urandom_range(0, COLS - 1);
      send_at(stamp + settle_gap(), rv, cv);
      if ($urandom_range(3) == 0) begin
         send_at(stamp + $urandom_range(0, 3), 4'($urandom), 4'($urandom));
      end
      send_at(stamp + settle_gap(), rv, cv);
      repeat ($urandom_range(0, 2)) send_at(stamp + settle_gap(), rv, cv);
      repeat ($urandom_range(2, 4)) send_at(stamp + settle_gap(), '0, '0);
   endtask

   task automatic press_chord();
      logic [VEC_W-1:0] rv;
      logic [VEC_W-1:0] cv;
      rv = 4'($urandom_range(1, 15));
      cv = 4'($urandom_range(1, 15));
      repeat ($urandom_range(2, 3)) send_at(stamp + settle_gap(), rv, cv);
      if ($urandom_range(1)) begin
         rv = rv ^ (VEC_W'(1) << $urandom_range(0, ROWS - 1));
      end else begin
         cv = cv ^ (VEC_W'(1) << $urandom_range(0, COLS - 1));
      end
      repeat ($urandom_range(2, 3)) send_at(stamp + settle_gap(), rv, cv);
      repeat ($urandom_range(2, 5)) send_at(stamp + settle_gap(), '0, '0);
   endtask

   task automatic scan_noise();
      repeat ($urandom_range(1, 4)) begin
         send_at(stamp + ($urandom_range(1) ? settle_gap() : $urandom),
                 4'($urandom), 4'($urandom));
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_event(rsp_tdata);
         rsp_tready <= !reset && (steady || $urandom_range(99) >= 38);
      end
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] deb_set[7];
      logic [CFG_W-1:0] tmo_set[7];
      key_event_type    leftover;
      int               target;
      int               pick;
      deb_set = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'($urandom), 10'd10,
                  10'($urandom_range(1, 20))};
      tmo_set = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'($urandom), 10'd100,
                  10'($urandom_range(20, 200))};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settle, hold, press and release of one key
      send_at(32'd100, 4'h1, 4'h1);
      send_at(32'd105, 4'h1, 4'h1);
      send_at(32'd110, 4'h1, 4'h1);
      send_at(32'd111, 4'h0, 4'h0);
      send_at(32'd125, 4'h0, 4'h0);
      // corner key, then a column change with the row unchanged
      send_at(32'd200, 4'h8, 4'h8);
      send_at(32'd210, 4'h8, 4'h8);
      send_at(32'd220, 4'h8, 4'hc);
      send_at(32'd230, 4'h8, 4'hc);
      // row change with two columns held cannot be resolved
      send_at(32'd240, 4'hc, 4'hc);
      send_at(32'd250, 4'hc, 4'hc);
      send_at(32'd260, 4'hc, 4'h4);
      // pending change abandoned after the timeout
      send_at(32'd300, 4'hc, 4'h4);
      send_at(32'd400, 4'h1, 4'h4);
      send_at(32'd600, 4'hc, 4'h4);
      // timestamp wrap and a backwards timestamp
      send_at(32'hffff_fffa, 4'h2, 4'h2);
      send_at(32'h0000_0004, 4'h2, 4'h2);
      send_at(32'h8000_0000, 4'h4, 4'h1);
      send_at(32'h7fff_ffff, 4'h4, 4'h1);
      // all clear releases held keys one at a time
      send_at(32'h8000_0010, 4'h0, 4'h0);
      send_at(32'h8000_0011, 4'h0, 4'h0);
      send_at(32'h8000_0020, 4'h0, 4'h0);
      send_at(32'h8000_0021, 4'h0, 4'h0);
      send_at(32'h8000_0022, 4'h0, 4'h0);
      send_at(32'h8000_0023, 4'h0, 4'h0);

      stamp  = $urandom;
      target = sent;
      for (int ph = 0; ph < 7; ph++) begin
         wait_drained();
         write_settings(deb_set[ph], tmo_set[ph]);
         steady = (ph == 3);
         target += 261;
         while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               tap_key();
            end else if (pick < 75) begin
               press_chord();
            end else begin
               scan_noise();
            end
         end
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      for (int n = 0; n < 20000 && tracker.queued.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      while (tracker.queued.size() != 0) begin
         leftover = tracker.queued.pop_front();
         $display("%0t: missing event, expected action %0d key %0d, got none",
                  $time, leftover.action, leftover.key);
         tracker.mismatches++;
      end
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
